// ===== src/wfpg_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the foot path generator.
package wfpg_pkg;

  // Sine table depth (quarter wave) and index width
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int K_W = $clog2(SINE_TABLE_DEPTH + 1);

  // Field widths
  localparam int TIME_W = 32;
  localparam int P_W    = 24;
  localparam int C_W    = 16;
  localparam int PH_W   = 12;

  // Milliseconds to seconds*4096: floor(time*512/125) as time*M >> 39,
  // M = ceil(2^48/125); exact for every 32-bit stamp. Two stages: split
  // product, then sum.
  localparam int          RECIP_W  = 42;
  localparam logic [41:0] RECIP_M  = 42'd2251799813686;
  localparam int          RECIP_SH = 39;
  localparam int          M_LO_W   = 21;
  localparam int          A_PW     = TIME_W + M_LO_W;
  localparam int          A_SW     = A_PW + M_LO_W;
  localparam int          A_STAGES = 2;
  localparam int          T_W      = 35;

  // Queue between the timing front and the path back end
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register indexes of the configuration port
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [P_W-1:0] PERIOD_RESET = 24'd4096;

  // Item passed from the front to the back end
  typedef struct packed {
    logic            active;
    logic [PH_W-1:0] phase;
  } front_item_t;

  typedef logic [12:0] sine_tbl_t [0:SINE_TABLE_DEPTH];

  // Build round(4096*sin(pi/2*i/D)) with a Taylor series in Q30
  function automatic sine_tbl_t build_sine();
    sine_tbl_t   tb;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (64'd1686629713 * 64'(i)) / SINE_TABLE_DEPTH;
      sum  = x;
      term = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (k)
          1: term = term / 6;
          2: term = term / 20;
          3: term = term / 42;
          4: term = term / 72;
          5: term = term / 110;
          6: term = term / 156;
          7: term = term / 210;
          default: term = term / 272;
        endcase
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      rnd   = (sum * 64'd4096 + 64'd536870912) >> 30;
      tb[i] = rnd[12:0];
    end
    return tb;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine();

endpackage

// ===== src/walking_foot_path_generator_top.sv =====
// Throughput: one item per cycle while the queue has room, via bit-per-stage dividers.
// Front (49 stages) and back (4 stages) are split by a 4-entry queue, each stalls alone.
// Reset: asynchronous, active low; clears valid bits and queue, height and width to 0,
// step period to 4096.
// Top level of the walking foot path generator with its configuration registers.
module walking_foot_path_generator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] foot_x_o,
  output logic signed [15:0] foot_y_o,
  output logic               result_valid_o
);
  import wfpg_pkg::*;

  logic signed [15:0] height_q;
  logic signed [15:0] width_q;
  logic [P_W-1:0]     period_q;
  logic               wr_en;

  logic               q_push, q_pop, q_full, q_empty;
  front_item_t        push_item, pop_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      width_q  <= '0;
      period_q <= PERIOD_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HEIGHT: height_q <= pwdata[15:0];
        REG_WIDTH:  width_q  <= pwdata[15:0];
        REG_PERIOD: period_q <= pwdata[P_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[3:2])
      REG_HEIGHT: prdata = {16'b0, height_q};
      REG_WIDTH:  prdata = {16'b0, width_q};
      REG_PERIOD: prdata = {8'b0, period_q};
      default:    prdata = '0;
    endcase
  end

  wfpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .time_ms_i     (time_ms_i),
    .step_period_i (period_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .push_item_o   (push_item)
  );

  wfpg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  wfpg_shaper u_shaper (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (pop_item),
    .pop_o          (q_pop),
    .path_height_i  (height_q),
    .path_width_i   (width_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .foot_x_o       (foot_x_o),
    .foot_y_o       (foot_y_o),
    .result_valid_o (result_valid_o)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("push into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // A disabled result carries zero targets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !result_valid_o) |-> (foot_x_o == 16'sd0 && foot_y_o == 16'sd0))
    else $error("disabled result with nonzero targets");

endmodule

// ===== src/wfpg_front.sv =====
// Timing front end: millisecond stamp to phase within the step period, pipelined dividers.
module wfpg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [31:0]                 time_ms_i,
  input  logic [wfpg_pkg::P_W-1:0]    step_period_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output wfpg_pkg::front_item_t       push_item_o
);
  import wfpg_pkg::*;

  localparam int NS = A_STAGES + T_W + PH_W;

  logic          en;
  logic [NS-1:0] vld_q;
  logic [NS-1:0] zero_q;

  logic [A_PW-1:0]  a_plo_q;
  logic [A_PW-1:0]  a_plo_d;
  logic [A_PW-1:0]  a_phi_q;
  logic [A_PW-1:0]  a_phi_d;
  logic [A_SW-1:0]  a_sum;
  logic [T_W-1:0]   a_quo_q;
  logic [T_W-1:0]   a_quo_d;

  logic [P_W-1:0]   b_rem_q [T_W];
  logic [P_W-1:0]   b_rem_d [T_W];
  logic [T_W-1:0]   b_dvd_q [T_W];
  logic [T_W-1:0]   b_dvd_d [T_W];

  logic [P_W-1:0]   c_rem_q [PH_W];
  logic [P_W-1:0]   c_rem_d [PH_W];
  logic [PH_W-1:0]  c_quo_q [PH_W];
  logic [PH_W-1:0]  c_quo_d [PH_W];

  // Advance the whole front while the queue has room
  assign en          = !q_full_i;
  assign in_ready_o  = en;
  assign push_o      = en && vld_q[NS-1];
  assign push_item_o = '{active: !zero_q[NS-1], phase: c_quo_q[PH_W-1]};

  // Multiply the stamp by the reciprocal of 125/512, low and high halves apart
  assign a_plo_d = A_PW'(time_ms_i) * A_PW'(RECIP_M[M_LO_W-1:0]);
  assign a_phi_d = A_PW'(time_ms_i) * A_PW'(RECIP_M[RECIP_W-1:M_LO_W]);

  // Sum the halves and keep the integer part: seconds*4096
  assign a_sum   = {a_phi_q, {M_LO_W{1'b0}}} + A_SW'(a_plo_q);
  assign a_quo_d = a_sum[RECIP_SH +: T_W];

  // Reduce seconds*4096 modulo the period, one bit per stage
  always_comb begin
    logic [P_W-1:0] r;
    logic [T_W-1:0] d;
    logic [P_W:0]   t;
    for (int s = 0; s < T_W; s++) begin
      if (s == 0) begin
        r = '0;
        d = a_quo_q;
      end else begin
        r = b_rem_q[s-1];
        d = b_dvd_q[s-1];
      end
      t = {r, d[T_W-1]};
      d = d << 1;
      if (t >= {1'b0, step_period_i}) begin
        t = t - {1'b0, step_period_i};
      end
      b_rem_d[s] = t[P_W-1:0];
      b_dvd_d[s] = d;
    end
  end

  // Scale the remainder to a 12-bit fraction of the period
  always_comb begin
    logic [P_W-1:0]  r;
    logic [PH_W-1:0] q;
    logic [P_W:0]    t;
    for (int s = 0; s < PH_W; s++) begin
      if (s == 0) begin
        r = b_rem_q[T_W-1];
        q = '0;
      end else begin
        r = c_rem_q[s-1];
        q = c_quo_q[s-1];
      end
      t = {r, 1'b0};
      if (t >= {1'b0, step_period_i}) begin
        t = t - {1'b0, step_period_i};
        q = {q[PH_W-2:0], 1'b1};
      end else begin
        q = {q[PH_W-2:0], 1'b0};
      end
      c_rem_d[s] = t[P_W-1:0];
      c_quo_d[s] = q;
    end
  end

  // Shift item valid bits along the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // Hold stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q  <= {zero_q[NS-2:0], (step_period_i == '0)};
      a_plo_q <= a_plo_d;
      a_phi_q <= a_phi_d;
      a_quo_q <= a_quo_d;
      for (int s = 0; s < T_W; s++) begin
        b_rem_q[s] <= b_rem_d[s];
        b_dvd_q[s] <= b_dvd_d[s];
      end
      for (int s = 0; s < PH_W; s++) begin
        c_rem_q[s] <= c_rem_d[s];
        c_quo_q[s] <= c_quo_d[s];
      end
    end
  end

endmodule

// ===== src/wfpg_fifo.sv =====
// Short item queue between the timing front and the path back end.
module wfpg_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wfpg_pkg::front_item_t push_item_i,
  input  logic                  pop_i,
  output wfpg_pkg::front_item_t pop_item_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import wfpg_pkg::*;

  front_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q;
  logic [FIFO_AW-1:0]   rd_q;
  logic [FIFO_AW:0]     cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o     = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/wfpg_shaper.sv =====
// Path back end: phase to foot x and y targets through table lookup and multipliers.
module wfpg_shaper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  wfpg_pkg::front_item_t      q_item_i,
  output logic                       pop_o,
  input  logic signed [15:0]         path_height_i,
  input  logic signed [15:0]         path_width_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         foot_x_o,
  output logic signed [15:0]         foot_y_o,
  output logic                       result_valid_o
);
  import wfpg_pkg::*;

  localparam int KP_W = 13 + K_W;

  logic en;
  logic v1_q, v2_q, v3_q, vo_q;

  // Half width, truncated toward zero
  logic [16:0]        w17;
  logic signed [15:0] hw;

  // Stage 1: segment, ramp and signed sine
  logic               act1_q, dome1_q, fall1_q;
  logic [11:0]        ramp1_q;
  logic signed [13:0] s1_q;
  logic signed [14:0] u;
  logic [14:0]        mag15;
  logic [KP_W-1:0]    kp;
  logic [K_W-1:0]     k;
  logic signed [13:0] sval;
  logic signed [13:0] s1_d;

  // Stage 2: products
  logic               act2_q, dome2_q, fall2_q;
  logic signed [29:0] px2_q;
  logic [24:0]        sq2_q;
  logic signed [13:0] ma;
  logic signed [15:0] mb;
  logic signed [27:0] sq_full;

  // Stage 3: x target and height product
  logic               act3_q;
  logic signed [15:0] x3_q;
  logic signed [29:0] py3_q;
  logic signed [29:0] px_half;
  logic signed [29:0] x_full;
  logic signed [25:0] nsq;
  logic signed [25:0] ysc_full;
  logic signed [13:0] ysc;
  logic signed [29:0] x3_d;

  // Output register
  logic signed [15:0] fx_q, fy_q;
  logic               rv_q;
  logic signed [29:0] py_sh;

  assign en    = !vo_q || out_ready_i;
  assign pop_o = en && !q_empty_i;

  assign w17 = {path_width_i[15], path_width_i} + {16'b0, path_width_i[15]};
  assign hw  = w17[16:1];

  // Look up the sine for the dome
  always_comb begin
    u     = $signed({1'b0, q_item_i.phase, 2'b00}) - 15'sd8192;
    mag15 = u[14] ? 15'(-u) : 15'(u);
    kp    = KP_W'(mag15[12:0]) * KP_W'(SINE_TABLE_DEPTH) + KP_W'(2048);
    if ((kp >> 12) > KP_W'(SINE_TABLE_DEPTH)) begin
      k = K_W'(SINE_TABLE_DEPTH);
    end else begin
      k = K_W'(kp >> 12);
    end
    sval = $signed({1'b0, SINE_TBL[k]});
    s1_d = u[14] ? -sval : sval;
  end

  // Select multiplier operands
  always_comb begin
    ma      = dome1_q ? -s1_q : $signed({2'b00, ramp1_q});
    mb      = dome1_q ? path_width_i : hw;
    sq_full = s1_q * s1_q;
  end

  // Finish x and form the height scale
  always_comb begin
    px_half  = (px2_q + 30'(px2_q[29])) >>> 1;
    nsq      = -$signed({1'b0, sq2_q});
    ysc_full = (nsq >>> 12) + 26'sd4096;
    ysc      = dome2_q ? ysc_full[13:0] : 14'sd0;
    if (dome2_q) begin
      x_full = px_half >>> 12;
    end else begin
      x_full = px2_q >>> 12;
    end
    x3_d  = fall2_q ? (x_full - 30'(hw)) : x_full;
    py_sh = py3_q >>> 12;
  end

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= !q_empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Hold stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q  <= q_item_i.active;
      dome1_q <= q_item_i.phase[11] ^ q_item_i.phase[10];
      fall1_q <= q_item_i.phase[11] & q_item_i.phase[10];
      ramp1_q <= {q_item_i.phase[9:0], 2'b00};
      s1_q    <= s1_d;

      act2_q  <= act1_q;
      dome2_q <= dome1_q;
      fall2_q <= fall1_q;
      px2_q   <= ma * mb;
      sq2_q   <= sq_full[24:0];

      act3_q  <= act2_q;
      x3_q    <= x3_d[15:0];
      py3_q   <= ysc * path_height_i;

      rv_q    <= act3_q;
      fx_q    <= act3_q ? x3_q : 16'sd0;
      fy_q    <= act3_q ? py_sh[15:0] : 16'sd0;
    end
  end

  assign out_valid_o    = vo_q;
  assign foot_x_o       = fx_q;
  assign foot_y_o       = fy_q;
  assign result_valid_o = rv_q;

endmodule

// ===== dv/tb_walking_foot_path_generator_top.sv =====
// Self-checking testbench of the walking foot path generator top level.
`timescale 1ns / 1ps

module tb_walking_foot_path_generator_top;
  import wfpg_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 80;
  localparam int RAND_PHASES = 10;
  localparam int RAND_ITEMS = 125;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               v;
  } foot_target_t;

  // One row of the directed stimulus
  typedef struct {
    bit                 set_regs;
    logic signed [15:0] height;
    logic signed [15:0] width;
    logic [23:0]        period;
    logic [31:0]        stamp;
    bit                 typed;
    foot_target_t       want;
  } path_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [31:0]        time_ms_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] foot_x_o;
  logic signed [15:0] foot_y_o;
  logic               result_valid_o;

  // Predictor copy of the registers and the quarter-wave table
  logic signed [15:0] height_q;
  logic signed [15:0] width_q;
  logic [23:0]        period_q;
  longint             quarter_sin [0:SINE_TABLE_DEPTH];

  foot_target_t       target_q [$];
  int                 n_errors;
  int                 n_results;
  int                 idle_cycles;
  int                 hold_cnt;
  bit                 long_hold_done;
  path_row_t          rows [$];

  walking_foot_path_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .foot_x_o       (foot_x_o),
    .foot_y_o       (foot_y_o),
    .result_valid_o (result_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fill the sine table: round(4096*sin(pi/2*i/D)) by Taylor series in Q30
  function automatic void fill_sine();
    longint unsigned ang;
    longint unsigned acc;
    longint unsigned trm;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      ang = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      acc = ang;
      trm = ang;
      for (int k = 1; k <= 8; k++) begin
        trm = (trm * ang) >> 30;
        trm = (trm * ang) >> 30;
        trm = trm / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - trm;
        else acc = acc + trm;
      end
      quarter_sin[i] = longint'((acc * 64'd4096 + 64'd536870912) >> 30);
    end
  endfunction

  // Work out the foot target of one time stamp
  function automatic foot_target_t foot_target(input logic [31:0] stamp);
    foot_target_t r;
    longint       ticks;
    longint       ph;
    longint       per;
    longint       hw;
    longint       u;
    longint       mag;
    longint       k;
    longint       s;
    longint       fx;
    longint       fy;
    r = '{x: '0, y: '0, v: 1'b0};
    if (period_q == 0) return r;
    per   = longint'(period_q);
    ticks = (longint'(stamp) * 4096) / 1000;
    ph    = ((ticks % per) * 4096) / per;
    hw    = longint'(width_q) / 2;
    fy    = 0;
    if (ph < 1024) begin
      fx = ((ph * 4) * hw) >>> 12;
    end else if (ph < 3072) begin
      u   = (ph - 1024) * 4 - 4096;
      mag = (u < 0) ? -u : u;
      k   = (mag * SINE_TABLE_DEPTH + 2048) >> 12;
      if (k > SINE_TABLE_DEPTH) k = SINE_TABLE_DEPTH;
      s = quarter_sin[k];
      if (u < 0) s = -s;
      fx = ((-s * longint'(width_q)) / 2) >>> 12;
      fy = ((((-s * s) >>> 12) + 4096) * longint'(height_q)) >>> 12;
    end else begin
      fx = (((ph - 3072) * 4 * hw) >>> 12) - hw;
    end
    r.x = fx[15:0];
    r.y = fy[15:0];
    r.v = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Write one register over the configuration port
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEIGHT: height_q = value[15:0];
      REG_WIDTH:  width_q  = value[15:0];
      REG_PERIOD: period_q = value[23:0];
      default: ;
    endcase
  endtask

  // Hold input until every target is back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (target_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic signed [15:0] h, input logic signed [15:0] w,
                           input logic [23:0] p);
    drain();
    reg_write(REG_HEIGHT, {$urandom} << 16 | 32'(h[15:0]));
    reg_write(REG_WIDTH, {$urandom} << 16 | 32'(w[15:0]));
    reg_write(REG_PERIOD, {8'($urandom), p});
  endtask

  // Offer one item, keep valid high across back-to-back items
  task automatic send_stamp(input logic [31:0] stamp, input bit typed,
                            input foot_target_t want);
    int gap;
    in_valid_i <= 1'b1;
    time_ms_i  <= stamp;
    @(posedge clk_i iff in_ready_o);
    target_q.push_back(typed ? want : foot_target(stamp));
    gap = $urandom_range(0, 99);
    if (gap < 60) gap = 0;
    else if (gap < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(signed'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'hffffff;
      3, 4: return 24'($urandom_range(1, 100));
      5, 6: return 24'($urandom_range(100, 100000));
      default: return 24'($urandom);
    endcase
  endfunction

  // Compare each result item with the oldest target, drive receiver stalls
  always @(posedge clk_i) begin
    foot_target_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (target_q.size() == 0) begin
        report_mismatch("unexpected result, foot_x", foot_x_o, 0);
      end else begin
        w = target_q.pop_front();
        if (foot_x_o !== w.x) report_mismatch("foot_x", foot_x_o, w.x);
        if (foot_y_o !== w.y) report_mismatch("foot_y", foot_y_o, w.y);
        if (result_valid_o !== w.v) report_mismatch("result_valid", result_valid_o, w.v);
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && n_results >= 300) begin
      long_hold_done <= 1'b1;
      hold_cnt       <= 400;
      out_ready_i    <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      hold_cnt    <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
    end
  end

  // Stop on a long stretch with no item moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic path_row_t row(input logic [31:0] stamp, input bit typed = 0,
                                    input logic signed [15:0] wx = 0,
                                    input logic signed [15:0] wy = 0,
                                    input logic wv = 0);
    path_row_t r;
    r = '{set_regs: 0, height: 0, width: 0, period: 0, stamp: stamp, typed: typed,
          want: '{x: wx, y: wy, v: wv}};
    return r;
  endfunction

  function automatic path_row_t cfg_row(input logic signed [15:0] h,
                                        input logic signed [15:0] w,
                                        input logic [23:0] p, input logic [31:0] stamp);
    path_row_t r;
    r = row(stamp);
    r.set_regs = 1;
    r.height   = h;
    r.width    = w;
    r.period   = p;
    return r;
  endfunction

  initial begin
    path_row_t r;
    fill_sine();
    height_q       = '0;
    width_q        = '0;
    period_q       = PERIOD_RESET;
    n_errors       = 0;
    n_results      = 0;
    idle_cycles    = 0;
    hold_cnt       = 0;
    long_hold_done = 0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    time_ms_i      = '0;
    out_ready_i    = 1'b0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // After reset: zero height and width give a flat path at rest
    rows.push_back(row(32'd0, 1, 0, 0, 1));
    rows.push_back(row(32'hffffffff, 1, 0, 0, 1));
    rows.push_back(row(32'd500, 1, 0, 0, 1));
    // Zero period: no targets
    rows.push_back(cfg_row(16'sh7fff, 16'sh7fff, 24'd0, 32'd0));
    rows[$].typed = 1;
    rows.push_back(row(32'hffffffff, 1, 0, 0, 0));
    rows.push_back(row(32'd750, 1, 0, 0, 0));
    // One-second period: segment edges of rise, dome, fall
    rows.push_back(cfg_row(16'sh7fff, 16'sh8000, 24'd4096, 32'd0));
    rows.push_back(row(32'd249));
    rows.push_back(row(32'd250));
    rows.push_back(row(32'd500));
    rows.push_back(row(32'd749));
    rows.push_back(row(32'd750));
    rows.push_back(row(32'd999));
    // Longest and shortest periods, odd stride width
    rows.push_back(cfg_row(16'sh8000, 16'sh7fff, 24'hffffff, 32'hffffffff));
    rows.push_back(row(32'd123456789));
    rows.push_back(row(32'd2000000));
    rows.push_back(cfg_row(16'sd100, -16'sd7, 24'd1, 32'd12345));
    rows.push_back(cfg_row(16'sd100, -16'sd7, 24'd3, 32'd1));
    rows.push_back(row(32'd2));
    rows.push_back(row(32'd3));
    rows.push_back(row(32'h80000000));

    foreach (rows[i]) begin
      r = rows[i];
      if (r.set_regs) load_regs(r.height, r.width, r.period);
      send_stamp(r.stamp, r.typed, r.want);
    end

    // Write to an unknown register index: must leave the setting alone
    drain();
    reg_write(2'd3, 32'hffffffff);
    send_stamp(32'd600, 0, '{x: 0, y: 0, v: 0});

    // Random phases with fresh settings; extremes come up now and then
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_regs(pick_coef(), pick_coef(), (ph == 1) ? 24'd4096 : pick_period());
      for (int n = 0; n < RAND_ITEMS; n++) begin
        send_stamp(($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 20000)) : $urandom,
                   0, '{x: 0, y: 0, v: 0});
      end
    end

    drain();
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
